>>> src/multi_voice_audio_mixer_core_defines.svh
// Assertion macros for the voice mixer core.
// Included by the top level; no other dependencies.
`ifndef MULTI_VOICE_AUDIO_MIXER_CORE_DEFINES_SVH
`define MULTI_VOICE_AUDIO_MIXER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MVM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("mixer check failed");
// Implication checked in the cycle after the condition.
`define MVM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("mixer check failed");
`endif

>>> src/mvm_pkg.sv
// Package for the voice mixer: kinds, status codes, sizes.
// No dependencies.
package mvm_pkg;
  localparam int NUM_VOICES_DEF    = 16;
  localparam int NUM_CLIPS_DEF     = 16;
  localparam int SAMPLE_FRAMES_DEF = 65536;
  localparam int SAMPLE_WIDTH      = 16;
  localparam logic [16:0] MAX_CLIP_FRAMES = 17'h10000;
  localparam logic [15:0] UNITY_GAIN = 16'd256;

  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_DEFINE = 3'd1,
    KIND_PLAY   = 3'd2,
    KIND_VOLUME = 3'd3,
    KIND_MIX    = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_NO_VOICE = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [15:0] left_in;
    logic [15:0] right_in;
    logic [3:0]  clip;
    logic [16:0] clip_length;
    logic [7:0]  repeats;
    logic [15:0] voice_id;
    logic [15:0] volume;
  } cmd_t;

  typedef struct packed {
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic [15:0] new_voice;
    logic [1:0]  status;
    logic [4:0]  active_voices;
  } res_t;
endpackage

>>> src/mvm_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on mvm_pkg.
interface mvm_cmd_if;
  import mvm_pkg::*;
  logic valid;
  logic ready;
  logic [2:0]  kind;
  logic [15:0] address;
  logic [15:0] left_in;
  logic [15:0] right_in;
  logic [3:0]  clip;
  logic [16:0] clip_length;
  logic [7:0]  repeats;
  logic [15:0] voice_id;
  logic [15:0] volume;
  modport source (output valid, kind, address, left_in, right_in, clip, clip_length,
                  repeats, voice_id, volume, input ready);
  modport sink (input valid, kind, address, left_in, right_in, clip, clip_length,
                repeats, voice_id, volume, output ready);
endinterface

interface mvm_res_if;
  logic valid;
  logic ready;
  logic [15:0] left_out;
  logic [15:0] right_out;
  logic [15:0] new_voice;
  logic [1:0]  status;
  logic [4:0]  active_voices;
  modport source (output valid, left_out, right_out, new_voice, status, active_voices,
                  input ready);
  modport sink (input valid, left_out, right_out, new_voice, status, active_voices,
                output ready);
endinterface

>>> src/multi_voice_audio_mixer_core.sv
// Stereo sample-playback mixer. Commands queue in a two-entry buffer; the
// engine runs one at a time. Write and define go straight to the result; play and
// set volume sweep the voice slots; mix sweeps the slots twice (retire pass, then
// one sample-memory fetch per slot: fetch, wait and accumulate for a playing
// voice, fetch and accumulate for an empty slot), with one fetch of the
// registered sample RAM in flight at a time.
// Depends on mvm_pkg, mvm_if, mvm_front, mvm_engine, mvm_ram.
`include "multi_voice_audio_mixer_core_defines.svh"
module multi_voice_audio_mixer_core #(
  parameter int NUM_VOICES    = mvm_pkg::NUM_VOICES_DEF,
  parameter int NUM_CLIPS     = mvm_pkg::NUM_CLIPS_DEF,
  parameter int SAMPLE_FRAMES = mvm_pkg::SAMPLE_FRAMES_DEF
) (
  input logic       clk,
  input logic       rst,
  mvm_cmd_if.sink   cmd,
  mvm_res_if.source res
);
  import mvm_pkg::*;
  cmd_t q_data;
  logic q_valid, q_pop, busy;

  mvm_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst(rst), .cmd(cmd), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  mvm_engine #(.NUM_VOICES(NUM_VOICES), .NUM_CLIPS(NUM_CLIPS),
               .SAMPLE_FRAMES(SAMPLE_FRAMES)) u_engine (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .res(res), .busy(busy)
  );

  // Engine pops only when idle and queue not empty
  `MVM_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, q_valid && !busy)
  // A popped command keeps the engine busy next cycle
  `MVM_ASSERT_NEXT(a_pop_busy, clk, rst, q_pop, busy)
  // Status codes stay in range
  `MVM_ASSERT_IMP(a_status, clk, rst, res.valid, res.status != 2'd3)
endmodule

>>> src/mvm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module mvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/mvm_front.sv
// Front end: accepts commands and queues them for the engine.
// Depends on mvm_pkg.
module mvm_front #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  mvm_cmd_if.sink      cmd,
  output mvm_pkg::cmd_t q_data,
  output logic         q_valid,
  input  logic         q_pop
);
  import mvm_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          buf_q [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          push;
  cmd_t          in_c;

  assign in_c = '{kind: cmd.kind, address: cmd.address, left_in: cmd.left_in,
                  right_in: cmd.right_in, clip: cmd.clip, clip_length: cmd.clip_length,
                  repeats: cmd.repeats, voice_id: cmd.voice_id, volume: cmd.volume};
  assign cmd.ready = (count != (AW+1)'(DEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign q_data    = buf_q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) buf_q[wr_ptr] <= in_c;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule

>>> src/mvm_engine.sv
// Back end: executes one command at a time, sweeping voice slots for play, volume and mix.
// Depends on mvm_pkg and mvm_ram.
module mvm_engine #(
  parameter int NUM_VOICES    = 16,
  parameter int NUM_CLIPS     = 16,
  parameter int SAMPLE_FRAMES = 65536
) (
  input  logic          clk,
  input  logic          rst,
  input  mvm_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_pop,
  mvm_res_if.source     res,
  output logic          busy
);
  import mvm_pkg::*;
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
  localparam int MW = $clog2(SAMPLE_FRAMES);
  localparam int NW = $clog2(NUM_VOICES + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FETCH, S_WAIT, S_ACC, S_DONE} state_t;
  state_t state;

  cmd_t          c;
  logic [VW-1:0] vi;
  logic          vvalid [NUM_VOICES];
  logic [CW-1:0] vclip  [NUM_VOICES];
  logic [16:0]   vpos   [NUM_VOICES];
  logic [7:0]    vrep   [NUM_VOICES];
  logic [15:0]   vgain  [NUM_VOICES];
  logic [15:0]   vident [NUM_VOICES];
  logic [15:0]   cstart [NUM_CLIPS];
  logic [16:0]   clen   [NUM_CLIPS];
  logic [15:0]   next_ident;
  logic [NW-1:0] nactive;
  logic signed [47:0] suml, sumr;
  logic          any;
  logic          found;
  logic [15:0]   new_voice;
  logic [1:0]    status_code;
  logic signed [31:0] pl, pr;

  // Sample memory
  logic          mem_we;
  logic [MW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;
  logic [CW-1:0] cur_clip;
  logic [16:0]   cur_len;
  assign cur_clip  = vclip[vi];
  assign cur_len   = clen[cur_clip];
  assign mem_we    = (state == S_IDLE) && q_valid && (q_data.kind == KIND_WRITE);
  assign mem_raddr = MW'({1'b0, cstart[cur_clip]} + vpos[vi]);

  mvm_ram #(.WIDTH(32), .DEPTH(SAMPLE_FRAMES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(MW'(q_data.address)),
    .wdata({q_data.right_in, q_data.left_in}), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign q_pop = (state == S_IDLE) && q_valid;
  assign busy  = (state != S_IDLE);

  // Count valid slots
  always_comb begin
    nactive = '0;
    for (int i = 0; i < NUM_VOICES; i++) nactive = nactive + NW'(vvalid[i]);
  end

  function automatic logic [15:0] sat(input logic signed [47:0] s);
    logic signed [47:0] q;
    q = (s < 0) ? -((-s) >>> 8) : (s >>> 8);
    if (q > 48'sd32767) return 16'h7fff;
    if (q < -48'sd32768) return 16'h8000;
    return q[15:0];
  endfunction

  // Weighted samples of the fetched frame
  assign pl = $signed(mem_rdata[15:0]) * $signed({1'b0, vgain[vi]});
  assign pr = $signed(mem_rdata[31:16]) * $signed({1'b0, vgain[vi]});

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res.valid  <= 1'b0;
      next_ident <= '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        vvalid[i] <= 1'b0; vclip[i] <= '0; vpos[i] <= '0; vrep[i] <= '0;
        vgain[i] <= '0; vident[i] <= '0;
      end
      for (int i = 0; i < NUM_CLIPS; i++) begin
        cstart[i] <= '0; clen[i] <= '0;
      end
    end else begin
      // Drop the result once taken, unless a new one is loaded now
      if (res.valid && res.ready && state != S_DONE) res.valid <= 1'b0;
      case (state)
        S_IDLE: if (q_valid) begin
          c     <= q_data;
          vi    <= '0;
          suml  <= '0;
          sumr  <= '0;
          any   <= 1'b0;
          found <= 1'b0;
          new_voice   <= '0;
          status_code <= ST_OK;
          case (q_data.kind)
            KIND_WRITE: state <= S_DONE;
            KIND_DEFINE: begin
              cstart[CW'(q_data.clip)] <= q_data.address;
              clen[CW'(q_data.clip)] <= (q_data.clip_length > MAX_CLIP_FRAMES) ?
                                         MAX_CLIP_FRAMES : q_data.clip_length;
              state <= S_DONE;
            end
            KIND_PLAY, KIND_VOLUME, KIND_MIX: state <= S_SCAN;
            default: state <= S_DONE;
          endcase
        end
        S_SCAN: begin
          // One slot per cycle
          case (c.kind)
            KIND_PLAY: if (!found && !vvalid[vi]) begin
              found <= 1'b1;
              vvalid[vi] <= 1'b1; vclip[vi] <= CW'(c.clip); vpos[vi] <= '0;
              vrep[vi] <= c.repeats; vgain[vi] <= UNITY_GAIN; vident[vi] <= next_ident;
              new_voice <= next_ident;
              next_ident <= next_ident + 16'd1;
            end
            KIND_VOLUME: if (!found && vvalid[vi] && vident[vi] == c.voice_id) begin
              found <= 1'b1;
              vgain[vi] <= c.volume;
            end
            default: begin
              // Retire or restart a voice at clip end; an empty clip uses up all repeats
              if (vvalid[vi] && vpos[vi] >= cur_len) begin
                if (vrep[vi] == '0 || cur_len == '0) begin
                  vvalid[vi] <= 1'b0;
                  vrep[vi] <= '0;
                end else begin
                  vrep[vi] <= vrep[vi] - 8'd1;
                  vpos[vi] <= '0;
                end
              end
            end
          endcase
          if (vi == VW'(NUM_VOICES-1)) begin
            vi <= '0;
            if (c.kind == KIND_MIX) state <= S_FETCH;
            else begin
              if (c.kind == KIND_PLAY && !found && vvalid[vi]) status_code <= ST_NO_SLOT;
              if (c.kind == KIND_VOLUME && !found &&
                  !(vvalid[vi] && vident[vi] == c.voice_id)) status_code <= ST_NO_VOICE;
              state <= S_DONE;
            end
          end else vi <= vi + 1'b1;
        end
        S_FETCH: state <= vvalid[vi] ? S_WAIT : S_ACC;
        S_WAIT:  state <= S_ACC;
        S_ACC: begin
          if (vvalid[vi]) begin
            any  <= 1'b1;
            suml <= suml + 48'(pl);
            sumr <= sumr + 48'(pr);
            vpos[vi] <= vpos[vi] + 17'd1;
          end
          if (vi == VW'(NUM_VOICES-1)) state <= S_DONE;
          else begin
            vi <= vi + 1'b1;
            state <= S_FETCH;
          end
        end
        S_DONE: if (!res.valid || res.ready) begin
          res.left_out  <= (c.kind == KIND_MIX && any) ? sat(suml) : '0;
          res.right_out <= (c.kind == KIND_MIX && any) ? sat(sumr) : '0;
          res.new_voice <= new_voice;
          res.status    <= status_code;
          res.active_voices <= 5'(nactive);
          res.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
